[src/svf_pkg.sv]
// shared constants, codes and control types of the two-pole state-variable filter
package svf_pkg;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int STATE_BITS_DEF     = 32;
    localparam int COEF_FRAC_BITS_DEF = 20;

    // fixed field widths
    localparam int COEF_W     = 24;
    localparam int MIX_W      = 17;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MIX_SHIFT  = 16;

    // output select codes
    localparam logic [MODE_W-1:0] MODE_LP     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BP     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIX    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BYPASS = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_NORM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_WEIGHT = 3'd4;

    // register reset values
    localparam logic [COEF_W-1:0] COEF_ONE = 24'h100000;
    localparam logic [MIX_W-1:0]  MIX_ONE  = 17'h10000;
    localparam logic [MIX_W-1:0]  MIX_HALF = 17'h08000;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RHO,
        ST_CALC_T,
        ST_MUL_A0,
        ST_CALC_HP,
        ST_MUL_HP,
        ST_CALC_BP,
        ST_MUL_BP,
        ST_CALC_LP,
        ST_UPD_ONE,
        ST_UPD_TWO,
        ST_CALC_MIX,
        ST_FINAL
    } state_t;

    // multiplier signed operand
    typedef enum logic [2:0] {MA_Z1, MA_T, MA_HP, MA_BP, MA_LP} mul_a_t;

    // multiplier coefficient operand
    typedef enum logic [2:0] {MC_RHO, MC_A0, MC_ALPHA, MC_W, MC_WINV} mul_c_t;

    // adder second operand
    typedef enum logic [2:0] {OB_ZERO, OB_X, OB_Z1, OB_Z2, OB_AH, OB_AB, OB_MH} op_b_t;

    // adder third operand
    typedef enum logic [1:0] {OC_ZERO, OC_NZ2, OC_BP, OC_LP} op_c_t;

    // saturated adder result destination
    typedef enum logic [2:0] {
        DST_NONE, DST_T, DST_HP, DST_BP, DST_LP, DST_Z1, DST_Z2, DST_MIX
    } dst_t;

    // datapath control from the sequencer
    typedef struct packed {
        logic   mul_en;
        mul_a_t mul_a;
        mul_c_t mul_c;
        logic   use_prod;
        logic   neg_prod;
        logic   shift16;
        op_b_t  op_b;
        op_c_t  op_c;
        dst_t   dst;
        logic   ah_load;
        logic   ab_load;
        logic   mh_load;
        logic   out_load;
    } ctrl_t;

endpackage

[src/svf_mul.sv]
// shared registered signed multiplier
module svf_mul #(
    parameter int A_W = 32,
    parameter int C_W = 25
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [A_W-1:0]      a,
    input  logic signed [C_W-1:0]      c,
    output logic signed [A_W+C_W-1:0]  prod
);

    logic signed [A_W+C_W-1:0] prod_reg;

    // product register, loaded only when a multiply is issued
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * c;
        end
    end

    assign prod = prod_reg;

endmodule

[src/svf_alu.sv]
// product scaling, three-input add and saturation to the state range
module svf_alu #(
    parameter int STATE_BITS     = 32,
    parameter int COEF_FRAC_BITS = 20,
    parameter int PROD_W         = 57,
    parameter int SUM_W          = 38
) (
    input  svf_pkg::ctrl_t             ctrl,
    input  logic signed [PROD_W-1:0]   prod,
    input  logic signed [SUM_W-1:0]    op_b,
    input  logic signed [SUM_W-1:0]    op_c,
    output logic signed [SUM_W-1:0]    scaled,
    output logic signed [STATE_BITS-1:0] sat_val,
    output logic                       ovf
);
    import svf_pkg::*;

    localparam logic signed [SUM_W-1:0] ST_MAX =
        SUM_W'((65'sd1 <<< (STATE_BITS - 1)) - 65'sd1);
    localparam logic signed [SUM_W-1:0] ST_MIN = ~ST_MAX;

    logic signed [PROD_W-1:0] prod_sh;
    logic signed [SUM_W-1:0]  p_term;
    logic signed [SUM_W-1:0]  sum;
    logic                     ovf_hi;
    logic                     ovf_lo;

    // floor scaling of the product by the coefficient or mix fraction
    always_comb
    begin
        if (ctrl.shift16)
        begin
            prod_sh = prod >>> MIX_SHIFT;
        end
        else
        begin
            prod_sh = prod >>> COEF_FRAC_BITS;
        end
        scaled = SUM_W'(prod_sh);
    end

    // add and clamp
    always_comb
    begin
        if (!ctrl.use_prod)
        begin
            p_term = '0;
        end
        else if (ctrl.neg_prod)
        begin
            p_term = -scaled;
        end
        else
        begin
            p_term = scaled;
        end
        sum    = p_term + op_b + op_c;
        ovf_hi = sum > ST_MAX;
        ovf_lo = sum < ST_MIN;
        if (ovf_hi)
        begin
            sat_val = ST_MAX[STATE_BITS-1:0];
        end
        else if (ovf_lo)
        begin
            sat_val = ST_MIN[STATE_BITS-1:0];
        end
        else
        begin
            sat_val = sum[STATE_BITS-1:0];
        end
        ovf = ovf_hi | ovf_lo;
    end

endmodule

[src/svf_seq.sv]
// step sequencer driving the shared multiplier and adder
module svf_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [svf_pkg::MODE_W-1:0]   mode,
    input  logic                         out_free,
    output logic                         ready,
    output svf_pkg::ctrl_t               ctrl
);
    import svf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode > MODE_MIX)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_MUL_RHO;
                    end
                end
            end
            ST_MUL_RHO: state_next = ST_CALC_T;
            ST_CALC_T:  state_next = ST_MUL_A0;
            ST_MUL_A0:  state_next = ST_CALC_HP;
            ST_CALC_HP: state_next = ST_MUL_HP;
            ST_MUL_HP:  state_next = ST_CALC_BP;
            ST_CALC_BP: state_next = ST_MUL_BP;
            ST_MUL_BP:  state_next = ST_CALC_LP;
            ST_CALC_LP: state_next = ST_UPD_ONE;
            ST_UPD_ONE: state_next = ST_UPD_TWO;
            ST_UPD_TWO:
            begin
                if (mode == MODE_MIX)
                begin
                    state_next = ST_CALC_MIX;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_CALC_MIX: state_next = ST_FINAL;
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        ctrl  = '0;
        ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
            end
            ST_MUL_RHO:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_a  = MA_Z1;
                ctrl.mul_c  = MC_RHO;
            end
            ST_CALC_T:
            begin
                ctrl.use_prod = 1'b1;
                ctrl.neg_prod = 1'b1;
                ctrl.op_b     = OB_X;
                ctrl.op_c     = OC_NZ2;
                ctrl.dst      = DST_T;
            end
            ST_MUL_A0:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_a  = MA_T;
                ctrl.mul_c  = MC_A0;
            end
            ST_CALC_HP:
            begin
                ctrl.use_prod = 1'b1;
                ctrl.dst      = DST_HP;
            end
            ST_MUL_HP:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_a  = MA_HP;
                ctrl.mul_c  = MC_ALPHA;
            end
            ST_CALC_BP:
            begin
                ctrl.use_prod = 1'b1;
                ctrl.op_b     = OB_Z1;
                ctrl.dst      = DST_BP;
                ctrl.ah_load  = 1'b1;
            end
            ST_MUL_BP:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_a  = MA_BP;
                ctrl.mul_c  = MC_ALPHA;
            end
            ST_CALC_LP:
            begin
                ctrl.use_prod = 1'b1;
                ctrl.op_b     = OB_Z2;
                ctrl.dst      = DST_LP;
                ctrl.ab_load  = 1'b1;
            end
            ST_UPD_ONE:
            begin
                // integrator one update, mix highpass product in parallel
                ctrl.op_b   = OB_AH;
                ctrl.op_c   = OC_BP;
                ctrl.dst    = DST_Z1;
                ctrl.mul_en = 1'b1;
                ctrl.mul_a  = MA_HP;
                ctrl.mul_c  = MC_W;
            end
            ST_UPD_TWO:
            begin
                // integrator two update, keep scaled highpass share, issue lowpass share
                ctrl.op_b    = OB_AB;
                ctrl.op_c    = OC_LP;
                ctrl.dst     = DST_Z2;
                ctrl.shift16 = 1'b1;
                ctrl.mh_load = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_a   = MA_LP;
                ctrl.mul_c   = MC_WINV;
            end
            ST_CALC_MIX:
            begin
                ctrl.use_prod = 1'b1;
                ctrl.shift16  = 1'b1;
                ctrl.op_b     = OB_MH;
                ctrl.dst      = DST_MIX;
            end
            ST_FINAL:
            begin
                ctrl.out_load = out_free;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

endmodule

[src/state_variable_filter_2pole.sv]
// top level of the two-pole trapezoidal state-variable filter
//
// Input words arrive on s_tvalid/s_tready/s_tdata, one signed audio sample
// each; result words leave on m_tvalid/m_tready/m_tdata with the overflow
// flag on m_tuser. Coefficients and the output select are to be written
// on the cfg_we/cfg_index/cfg_data port only while no sample is in flight;
// the user must keep to this, as the block itself does not enforce it.
// One shared 32x25 multiplier and one saturating adder are stepped by a
// sequencer through the filter equations; that chain of dependent
// multiply and add steps sets the rate; bypass skips the steps. A new
// word is taken only once the result before it is loaded for output.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; while the receiver stalls the
// sequencer holds in its last step and takes no new word, the states
// already updated. Reset clears both integrators, returns the registers
// to their defaults (lowpass, unity coefficients, half mix) and empties
// the output register.
module state_variable_filter_2pole #(
    parameter int SAMPLE_BITS    = svf_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS     = svf_pkg::STATE_BITS_DEF,
    parameter int COEF_FRAC_BITS = svf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [svf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_in from bit 0, zero padded to whole bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sample_out from bit 0, zero padded to whole bytes
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,
    // clipped
    output logic                              m_tuser
);
    import svf_pkg::*;

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int MULC_W = COEF_W + 1;
    localparam int PROD_W = STATE_BITS + MULC_W;
    localparam int EXTRA  = (COEF_FRAC_BITS < COEF_W) ? COEF_W - COEF_FRAC_BITS : 0;
    localparam int CORE_W = (STATE_BITS + EXTRA > SAMPLE_BITS) ?
                            STATE_BITS + EXTRA : SAMPLE_BITS;
    localparam int SUM_W  = CORE_W + 2;
    localparam int EXT_W  = ((STATE_BITS > SAMPLE_BITS) ? STATE_BITS : SAMPLE_BITS) + 1;
    localparam logic signed [EXT_W-1:0] SM_MAX =
        EXT_W'((65'sd1 <<< (SAMPLE_BITS - 1)) - 65'sd1);
    localparam logic signed [EXT_W-1:0] SM_MIN = ~SM_MAX;

    // configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [COEF_W-1:0] gain_norm_reg;
    logic [COEF_W-1:0] integ_gain_reg;
    logic [COEF_W-1:0] damping_reg;
    logic [MIX_W-1:0]  mix_weight_reg;

    // filter state and working values
    logic signed [STATE_BITS-1:0]  z1_reg;
    logic signed [STATE_BITS-1:0]  z2_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [STATE_BITS-1:0]  t_reg;
    logic signed [STATE_BITS-1:0]  hp_reg;
    logic signed [STATE_BITS-1:0]  bp_reg;
    logic signed [STATE_BITS-1:0]  lp_reg;
    logic signed [STATE_BITS-1:0]  mix_reg;
    logic signed [SUM_W-1:0]       ah_reg;
    logic signed [SUM_W-1:0]       ab_reg;
    logic signed [SUM_W-1:0]       mh_reg;
    logic                          clip_reg;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [SAMPLE_BITS-1:0]        out_sample_reg;
    logic                          out_clip_reg;

    ctrl_t                         ctrl;
    logic                          start;
    logic                          out_free;
    logic [MIX_W-1:0]              w_clamp;
    logic [MIX_W-1:0]              w_inv;
    logic signed [STATE_BITS-1:0]  mul_a;
    logic signed [MULC_W-1:0]      mul_c;
    logic signed [PROD_W-1:0]      prod;
    logic signed [SUM_W-1:0]       op_b;
    logic signed [SUM_W-1:0]       op_c;
    logic signed [SUM_W-1:0]       scaled;
    logic signed [STATE_BITS-1:0]  sat_val;
    logic                          ovf;
    logic signed [EXT_W-1:0]       sel_ext;
    logic                          fin_hi;
    logic                          fin_lo;
    logic [SAMPLE_BITS-1:0]        fin_sample;

    assign start    = s_tvalid & s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_LP;
            gain_norm_reg  <= COEF_ONE;
            integ_gain_reg <= COEF_ONE;
            damping_reg    <= COEF_ONE;
            mix_weight_reg <= MIX_HALF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[MODE_W-1:0];
                REG_GAIN_NORM:  gain_norm_reg  <= cfg_data[COEF_W-1:0];
                REG_INTEG_GAIN: integ_gain_reg <= cfg_data[COEF_W-1:0];
                REG_DAMPING:    damping_reg    <= cfg_data[COEF_W-1:0];
                REG_MIX_WEIGHT: mix_weight_reg <= cfg_data[MIX_W-1:0];
                default:        mode_reg       <= mode_reg;
            endcase
        end
    end

    // mix weight limited to one
    always_comb
    begin
        w_clamp = (mix_weight_reg > MIX_ONE) ? MIX_ONE : mix_weight_reg;
        w_inv   = MIX_ONE - w_clamp;
    end

    // sequencer
    svf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .mode     (mode_reg),
        .out_free (out_free),
        .ready    (s_tready),
        .ctrl     (ctrl)
    );

    // multiplier operand select
    always_comb
    begin
        case (ctrl.mul_a)
            MA_Z1:   mul_a = z1_reg;
            MA_T:    mul_a = t_reg;
            MA_HP:   mul_a = hp_reg;
            MA_BP:   mul_a = bp_reg;
            MA_LP:   mul_a = lp_reg;
            default: mul_a = z1_reg;
        endcase
        case (ctrl.mul_c)
            MC_RHO:   mul_c = MULC_W'(damping_reg);
            MC_A0:    mul_c = MULC_W'(gain_norm_reg);
            MC_ALPHA: mul_c = MULC_W'(integ_gain_reg);
            MC_W:     mul_c = MULC_W'(w_clamp);
            MC_WINV:  mul_c = MULC_W'(w_inv);
            default:  mul_c = MULC_W'(damping_reg);
        endcase
    end

    svf_mul #(
        .A_W (STATE_BITS),
        .C_W (MULC_W)
    ) u_mul (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .c    (mul_c),
        .prod (prod)
    );

    // adder operand select
    always_comb
    begin
        case (ctrl.op_b)
            OB_ZERO: op_b = '0;
            OB_X:    op_b = SUM_W'(x_reg);
            OB_Z1:   op_b = SUM_W'(z1_reg);
            OB_Z2:   op_b = SUM_W'(z2_reg);
            OB_AH:   op_b = ah_reg;
            OB_AB:   op_b = ab_reg;
            OB_MH:   op_b = mh_reg;
            default: op_b = '0;
        endcase
        case (ctrl.op_c)
            OC_ZERO: op_c = '0;
            OC_NZ2:  op_c = -(SUM_W'(z2_reg));
            OC_BP:   op_c = SUM_W'(bp_reg);
            OC_LP:   op_c = SUM_W'(lp_reg);
            default: op_c = '0;
        endcase
    end

    svf_alu #(
        .STATE_BITS     (STATE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .PROD_W         (PROD_W),
        .SUM_W          (SUM_W)
    ) u_alu (
        .ctrl    (ctrl),
        .prod    (prod),
        .op_b    (op_b),
        .op_c    (op_c),
        .scaled  (scaled),
        .sat_val (sat_val),
        .ovf     (ovf)
    );

    // integrator states and the clip flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z1_reg   <= '0;
            z2_reg   <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.dst == DST_Z1)
            begin
                z1_reg <= sat_val;
            end
            if (ctrl.dst == DST_Z2)
            begin
                z2_reg <= sat_val;
            end
            if (start)
            begin
                clip_reg <= 1'b0;
            end
            else if (ctrl.dst != DST_NONE)
            begin
                clip_reg <= clip_reg | ovf;
            end
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        case (ctrl.dst)
            DST_T:   t_reg   <= sat_val;
            DST_HP:  hp_reg  <= sat_val;
            DST_BP:  bp_reg  <= sat_val;
            DST_LP:  lp_reg  <= sat_val;
            DST_MIX: mix_reg <= sat_val;
            default: t_reg   <= t_reg;
        endcase
        if (ctrl.ah_load)
        begin
            ah_reg <= scaled;
        end
        if (ctrl.ab_load)
        begin
            ab_reg <= scaled;
        end
        if (ctrl.mh_load)
        begin
            mh_reg <= scaled;
        end
    end

    // output select and clamp to the sample range
    always_comb
    begin
        unique case (mode_reg)
            MODE_LP:  sel_ext = EXT_W'(lp_reg);
            MODE_HP:  sel_ext = EXT_W'(hp_reg);
            MODE_BP:  sel_ext = EXT_W'(bp_reg);
            MODE_MIX: sel_ext = EXT_W'(mix_reg);
            default:  sel_ext = EXT_W'(x_reg);
        endcase
        fin_hi = sel_ext > SM_MAX;
        fin_lo = sel_ext < SM_MIN;
        if (fin_hi)
        begin
            fin_sample = SM_MAX[SAMPLE_BITS-1:0];
        end
        else if (fin_lo)
        begin
            fin_sample = SM_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            fin_sample = sel_ext[SAMPLE_BITS-1:0];
        end
    end

    // output word valid
    always_comb
    begin
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_sample_reg <= fin_sample;
            out_clip_reg   <= clip_reg | fin_hi | fin_lo;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_sample_reg);
    assign m_tuser  = out_clip_reg;

endmodule

[sim/svf_checker.sv]
// output checker for the two-pole state-variable filter: tracks registers, predicts and compares
module svf_checker #(
    parameter int SAMPLE_W = svf_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_W  = svf_pkg::STATE_BITS_DEF,
    parameter int FRAC_W   = svf_pkg::COEF_FRAC_BITS_DEF,
    parameter int DATA_W   = ((SAMPLE_W + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [svf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [svf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [DATA_W-1:0]                s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [DATA_W-1:0]                m_tdata,
    input  logic                             m_tuser,
    output int                               errors,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import svf_pkg::*;

    typedef struct {
        longint sample;
        bit     clipped;
    } filt_result_t;

    // shadow copy of the registers and the two integrators
    logic [MODE_W-1:0] sel_mode;
    longint            norm_gain;
    longint            integ_gain;
    longint            damp_gain;
    longint            mix_gain;
    longint            integ_one;
    longint            integ_two;
    bit                clip_hit;

    filt_result_t      pending_outputs[$];
    int                fail_total = 0;
    int                queued     = 0;
    int                result_idx = 0;

    assign errors      = fail_total;
    assign outstanding = queued;

    // clamp to a signed range, noting any overflow for this word
    function automatic longint clamp(longint v, int bits);
        longint hi_lim;
        longint lo_lim;
        hi_lim = (64'sd1 <<< (bits - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (v > hi_lim)
        begin
            clip_hit = 1'b1;
            return hi_lim;
        end
        if (v < lo_lim)
        begin
            clip_hit = 1'b1;
            return lo_lim;
        end
        return v;
    endfunction

    // product with an unsigned coefficient, floored after the shift
    function automatic longint scaled(longint a, longint c, int s);
        return (a * c) >>> s;
    endfunction

    // one filter step: expected output word, integrators advanced
    function automatic filt_result_t filter_step(logic [SAMPLE_W-1:0] raw);
        longint       x;
        longint       t;
        longint       hp;
        longint       bp;
        longint       lp;
        longint       gh;
        longint       gb;
        longint       sel;
        longint       w;
        filt_result_t r;
        clip_hit = 1'b0;
        x = longint'($signed(raw));
        // bypass and the unused selects pass the sample, states untouched
        if (sel_mode > MODE_MIX)
        begin
            r.sample  = x;
            r.clipped = 1'b0;
            return r;
        end
        t  = clamp(x - scaled(integ_one, damp_gain, FRAC_W) - integ_two, STATE_W);
        hp = clamp(scaled(t, norm_gain, FRAC_W), STATE_W);
        gh = scaled(hp, integ_gain, FRAC_W);
        bp = clamp(gh + integ_one, STATE_W);
        gb = scaled(bp, integ_gain, FRAC_W);
        lp = clamp(gb + integ_two, STATE_W);
        case (sel_mode)
            MODE_LP: sel = lp;
            MODE_HP: sel = hp;
            MODE_BP: sel = bp;
            default:
            begin
                // weights above one act as one
                w   = (mix_gain > longint'(MIX_ONE)) ? longint'(MIX_ONE) : mix_gain;
                sel = clamp(scaled(hp, w, MIX_SHIFT)
                            + scaled(lp, longint'(MIX_ONE) - w, MIX_SHIFT), STATE_W);
            end
        endcase
        integ_one = clamp(gh + bp, STATE_W);
        integ_two = clamp(gb + lp, STATE_W);
        r.sample  = clamp(sel, SAMPLE_W);
        r.clipped = clip_hit;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        fail_total++;
        if (fail_total <= 20)
            $display("[%0t] %s mismatch on word %0d: got %0d, expected %0d",
                     $time, what, result_idx, got, want);
    endtask

    // watch the three ports
    always @(posedge clk or negedge rst_n)
    begin
        filt_result_t want;
        longint       got;
        if (!rst_n)
        begin
            sel_mode   = MODE_LP;
            norm_gain  = longint'(COEF_ONE);
            integ_gain = longint'(COEF_ONE);
            damp_gain  = longint'(COEF_ONE);
            mix_gain   = longint'(MIX_HALF);
            integ_one  = 0;
            integ_two  = 0;
            pending_outputs.delete();
            queued <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_outputs.push_back(filter_step(s_tdata[SAMPLE_W-1:0]));
            if (m_tvalid && m_tready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 20)
                        $display("[%0t] output word %0d with nothing pending",
                                 $time, result_idx);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    got  = longint'($signed(m_tdata[SAMPLE_W-1:0]));
                    if (got != want.sample)
                        report_mismatch("sample_out", got, want.sample);
                    if (m_tuser != want.clipped)
                        report_mismatch("clipped", longint'(m_tuser), longint'(want.clipped));
                end
                result_idx++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:       sel_mode   = cfg_data[MODE_W-1:0];
                    REG_GAIN_NORM:  norm_gain  = longint'(cfg_data[COEF_W-1:0]);
                    REG_INTEG_GAIN: integ_gain = longint'(cfg_data[COEF_W-1:0]);
                    REG_DAMPING:    damp_gain  = longint'(cfg_data[COEF_W-1:0]);
                    REG_MIX_WEIGHT: mix_gain   = longint'(cfg_data[MIX_W-1:0]);
                    default: ;
                endcase
            end
            queued <= pending_outputs.size();
        end
    end

endmodule

[sim/testbench.sv]
// stimulus, flow control and verdict for the two-pole state-variable filter
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import svf_pkg::*;

    localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
    localparam int DATA_W      = ((SAMPLE_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_WORDS = 50;
    localparam int LONG_HOLD   = 400;

    // select values with no output of their own
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tuser;
    int                    errors;
    int                    outstanding;
    int                    cycles    = 0;

    state_variable_filter_2pole u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    svf_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: runs of steady, random and sparse ready, one long hold mid-run
    initial
    begin
        int taken;
        int run_left;
        int run_style;
        int hold_left;
        bit long_done;
        taken     = 0;
        run_left  = 0;
        run_style = 0;
        hold_left = 0;
        long_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                taken++;
            if (!long_done && taken >= 150)
            begin
                long_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_style = $urandom_range(0, 3);
                    run_left  = $urandom_range(10, 60);
                end
                run_left--;
                case (run_style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // offer one word and hold it until taken
    task automatic send_item(logic [SAMPLE_W-1:0] sample);
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(sample);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // wait for every pending output word, then let the sequencer settle
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_config(logic [MODE_W-1:0] m, logic [COEF_W-1:0] a0,
                                logic [COEF_W-1:0] g, logic [COEF_W-1:0] rho,
                                logic [MIX_W-1:0] w);
        drain();
        write_reg(REG_MODE, CFG_DATA_W'(m));
        write_reg(REG_GAIN_NORM, a0);
        write_reg(REG_INTEG_GAIN, g);
        write_reg(REG_DAMPING, rho);
        write_reg(REG_MIX_WEIGHT, CFG_DATA_W'(w));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // coefficients of a stable filter from a random cutoff and damping
    task automatic pick_coefs(output logic [COEF_W-1:0] a0, output logic [COEF_W-1:0] g,
                              output logic [COEF_W-1:0] rho);
        longint gl;
        longint rl;
        longint den;
        gl  = $urandom_range(2000, 3 << 20);
        rl  = $urandom_range(30000, 2 << 20);
        den = (64'sd1 <<< 20) + ((2 * rl * gl) >>> 20) + ((gl * gl) >>> 20);
        a0  = COEF_W'((64'sd1 <<< 40) / den);
        g   = COEF_W'(gl);
        rho = COEF_W'(2 * rl + gl);
    endtask

    // mostly full-scale noise, some quiet signal, some rail values
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
                1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        if (r <= 3)
            return SAMPLE_W'($signed($urandom_range(0, 8191)) - 4096);
        return SAMPLE_W'($urandom());
    endfunction

    // one random setting followed by bursts of words
    task automatic random_phase(bit steady_sender);
        logic [MODE_W-1:0] m;
        logic [COEF_W-1:0] a0;
        logic [COEF_W-1:0] g;
        logic [COEF_W-1:0] rho;
        logic [MIX_W-1:0]  w;
        int                left;
        int                burst;
        int                gap;
        case ($urandom_range(0, 9))
            0, 1:    m = MODE_LP;
            2:       m = MODE_HP;
            3:       m = MODE_BP;
            4, 5, 6: m = MODE_MIX;
            7:       m = MODE_BYPASS;
            default: m = MODE_W'($urandom_range(0, 7));
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            a0  = COEF_W'($urandom());
            g   = COEF_W'($urandom());
            rho = COEF_W'($urandom());
        end
        else
            pick_coefs(a0, g, rho);
        w = ($urandom_range(0, 3) == 0) ? MIX_W'($urandom()) : MIX_W'($urandom_range(0, 65536));
        apply_config(m, a0, g, rho, w);
        left = PHASE_WORDS / 2 + $urandom_range(0, PHASE_WORDS);
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                send_item(pick_sample());
                burst--;
                left--;
            end
            gap = steady_sender ? 0 : $urandom_range(0, 20);
            if (gap > 0)
                idle_gap(gap);
        end
    endtask

    // main sequence
    initial
    begin
        logic [COEF_W-1:0] a0;
        logic [COEF_W-1:0] g;
        logic [COEF_W-1:0] rho;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: lowpass, unity coefficients, rails and sign flips
        send_item(24'h000000);
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        send_item(24'h7FFFFF);
        send_item(24'hFFFFFF);
        send_item(24'h000001);
        send_item(24'h800000);

        // largest coefficients in highpass, no damping: states pinned at the rails
        apply_config(MODE_HP, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, MIX_HALF);
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        send_item(24'h7FFFFF);
        send_item(24'h800000);

        // zero gains in bandpass with the largest damping
        apply_config(MODE_BP, 24'h000000, 24'h000000, 24'hFFFFFF, MIX_HALF);
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        send_item(24'h123456);

        // mix at both ends and above one
        pick_coefs(a0, g, rho);
        apply_config(MODE_MIX, a0, g, rho, '0);
        send_item(24'h400000);
        send_item(24'hC00000);
        apply_config(MODE_MIX, a0, g, rho, MIX_ONE);
        send_item(24'h400000);
        send_item(24'hC00000);
        apply_config(MODE_MIX, a0, g, rho, '1);
        send_item(24'h7FFFFF);
        send_item(24'h800000);

        // bypass and the unused selects
        apply_config(MODE_BYPASS, a0, g, rho, MIX_HALF);
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        apply_config(MODE_SPARE_HI, a0, g, rho, MIX_HALF);
        send_item(24'hA5A5A5);
        send_item(24'h5A5A5A);
        apply_config(MODE_SPARE_LO, a0, g, rho, MIX_HALF);
        send_item(24'h000001);

        // random settings, every third phase with the sender never pausing
        for (int p = 0; p < RAND_PHASES; p++)
            random_phase(p % 3 == 1);

        drain();
        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
